// ===== rtl/core/pd_pkg.sv =====
// shared types and character constants of the percent decoder
package pd_pkg;

  localparam int unsigned CapW = 13;
  localparam logic [CapW-1:0] CapReset = 13'd256;

  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChPlus    = 8'h2B;
  localparam logic [7:0] ChSpace   = 8'h20;

  localparam int unsigned MaxRes = 3;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       ovf;
  } result_t;

  // results caused by one input item
  typedef struct packed {
    logic [1:0]               cnt;
    result_t [MaxRes-1:0]     ent;
  } bundle_t;

  typedef struct packed {
    logic    push;
    bundle_t bundle;
  } front_out_t;

endpackage

// ===== rtl/core/pd_front.sv =====
// front stage: string state, escape parsing and capacity check per item
module pd_front import pd_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            acc_i,
  input  logic [7:0]      in_byte_i,
  input  logic            in_last_i,
  input  logic            cfg_we_i,
  input  logic [CapW-1:0] cfg_data_i,
  output front_out_t      front_o
);

  logic [CapW-1:0] cap_q;
  logic [1:0]      held_count_q, held_count_d;
  logic [7:0]      held_digit_q, held_digit_d;
  logic [CapW-1:0] out_count_q, out_count_d;
  logic            dropping_q, dropping_d;
  bundle_t         bundle;

  function automatic logic [4:0] hex_dec(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    return r;
  endfunction

  always_comb begin
    logic       alive;
    logic       do1, do2;
    logic [7:0] b1, b2;
    logic [4:0] hb, hh;
    logic [1:0] n;
    logic [7:0] b;
    n = 2'd0;
    alive = 1'b1;
    do1 = 1'b0;
    do2 = 1'b0;
    b = in_byte_i;
    b1 = b;
    b2 = b;
    hb = hex_dec(b);
    hh = hex_dec(held_digit_q);
    bundle = '0;
    held_count_d = held_count_q;
    held_digit_d = held_digit_q;
    out_count_d = out_count_q;
    dropping_d = dropping_q;

    if (dropping_q) begin
      if (in_last_i) begin
        dropping_d = 1'b0;
        held_count_d = 2'd0;
        held_digit_d = 8'd0;
        out_count_d = '0;
      end
    end else begin
      case (held_count_q)
        2'd0: begin
          do1 = 1'b1;
        end
        2'd1: begin
          if (hb[4] && !in_last_i) begin
            held_count_d = 2'd2;
            held_digit_d = b;
          end else begin
            held_count_d = 2'd0;
            bundle.ent[n] = '{data: ChPercent, last: 1'b0, ovf: 1'b0};
            n = n + 2'd1;
            do1 = 1'b1;
          end
        end
        default: begin
          held_count_d = 2'd0;
          if (hb[4] && hh[4]) begin
            bundle.ent[n] = '{data: {hh[3:0], hb[3:0]}, last: 1'b0, ovf: 1'b0};
            n = n + 2'd1;
          end else begin
            held_digit_d = 8'd0;
            bundle.ent[n] = '{data: ChPercent, last: 1'b0, ovf: 1'b0};
            n = n + 2'd1;
            do1 = 1'b1;
            b1 = held_digit_q;
            do2 = 1'b1;
          end
        end
      endcase

      for (int k = 0; k < 2; k++) begin
        if ((k == 0 ? do1 : do2) && alive) begin
          if (({1'b0, out_count_d} + 14'd1) >= {1'b0, cap_q}) begin
            if (n != 2'd3) begin
              bundle.ent[n] = '{data: 8'd0, last: 1'b1, ovf: 1'b1};
              n = n + 2'd1;
            end
            out_count_d = '0;
            held_count_d = 2'd0;
            held_digit_d = 8'd0;
            dropping_d = !in_last_i;
            alive = 1'b0;
          end else begin
            out_count_d = out_count_d + CapW'(1);
            if ((k == 0 ? b1 : b2) == ChPercent) begin
              held_count_d = 2'd1;
            end else if (n != 2'd3) begin
              bundle.ent[n] = '{data: ((k == 0 ? b1 : b2) == ChPlus) ? ChSpace
                                      : (k == 0 ? b1 : b2),
                                last: 1'b0, ovf: 1'b0};
              n = n + 2'd1;
            end
          end
        end
      end

      if (alive && in_last_i) begin
        if (held_count_d != 2'd0 && n != 2'd3) begin
          bundle.ent[n] = '{data: ChPercent, last: 1'b0, ovf: 1'b0};
          n = n + 2'd1;
        end
        if (n != 2'd0) bundle.ent[n - 2'd1].last = 1'b1;
        held_count_d = 2'd0;
        held_digit_d = 8'd0;
        out_count_d = '0;
        dropping_d = 1'b0;
      end
    end
    bundle.cnt = n;
  end

  assign front_o.push   = acc_i && (bundle.cnt != 2'd0);
  assign front_o.bundle = bundle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapReset;
      held_count_q <= 2'd0;
      held_digit_q <= 8'd0;
      out_count_q <= '0;
      dropping_q <= 1'b0;
    end else begin
      if (cfg_we_i) cap_q <= cfg_data_i;
      if (acc_i) begin
        held_count_q <= held_count_d;
        held_digit_q <= held_digit_d;
        out_count_q <= out_count_d;
        dropping_q <= dropping_d;
      end
    end
  end

endmodule

// ===== rtl/core/pd_fifo.sv =====
// bundle queue between the front and back stages
module pd_fifo import pd_pkg::*; #(
  parameter int unsigned Depth = 4
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  bundle_t wdata_i,
  output logic    full_o,
  input  logic    pop_i,
  output bundle_t rdata_o,
  output logic    empty_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);

  bundle_t          mem_q [Depth];
  logic [AddrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_ptr_q <= (wr_ptr_q == LastAddr) ? '0 : wr_ptr_q + AddrW'(1);
      if (do_pop) rd_ptr_q <= (rd_ptr_q == LastAddr) ? '0 : rd_ptr_q + AddrW'(1);
      if (do_push && !do_pop) cnt_q <= cnt_q + CntW'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - CntW'(1);
    end
  end

endmodule

// ===== rtl/core/pd_back.sv =====
// back stage: hands out the results of each bundle one at a time
module pd_back import pd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  bundle_t    bundle_i,
  input  logic       q_empty_i,
  output logic       q_pop_o,
  output logic       empty_o,
  input  logic       pop_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o,
  output logic       overflow_o
);

  bundle_t    cur_q;
  logic       cur_valid_q;
  logic [1:0] idx_q;
  logic       take, last_ent, load;
  result_t    res;

  assign take     = cur_valid_q && pop_i;
  assign last_ent = (idx_q == cur_q.cnt - 2'd1);
  assign load     = !cur_valid_q || (take && last_ent);
  assign q_pop_o  = load && !q_empty_i;

  assign res        = cur_q.ent[idx_q];
  assign empty_o    = !cur_valid_q;
  assign out_byte_o = res.data;
  assign out_last_o = res.last;
  assign overflow_o = res.ovf;

  always_ff @(posedge clk_i) begin
    if (load) cur_q <= bundle_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q <= 2'd0;
    end else if (load) begin
      cur_valid_q <= !q_empty_i;
      idx_q <= 2'd0;
    end else if (take) begin
      idx_q <= idx_q + 2'd1;
    end
  end

endmodule

// ===== rtl/core/percent_decoder.sv =====
// top level of the url percent decoder with plus as space
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------
//  input    | push / full            | in_byte_i, in_last_i
//  result   | empty / pop            | out_byte_o, out_last_o, overflow_o
//  config   | cfg_valid_i/cfg_ready_o| cfg_data_i (capacity)
//
//  one input item is taken per cycle while the bundle queue has room
//  each item makes zero to three results, which leave one per cycle
//  through the back stage, so the result port sets the sustained rate
//  reset is asynchronous, active low; capacity returns to 256
//  full rises when QueueDepth bundles wait behind a stalled result side
module percent_decoder import pd_pkg::*; #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push,
  output logic            full,
  input  logic [7:0]      in_byte_i,
  input  logic            in_last_i,
  output logic            empty,
  input  logic            pop,
  output logic [7:0]      out_byte_o,
  output logic            out_last_o,
  output logic            overflow_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [CapW-1:0] cfg_data_i
);

  front_out_t front;
  bundle_t    q_rdata;
  logic       q_empty, q_pop, acc;

  assign cfg_ready_o = 1'b1;
  assign acc = push && !full;

  pd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .acc_i      (acc),
    .in_byte_i  (in_byte_i),
    .in_last_i  (in_last_i),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .front_o    (front)
  );

  pd_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front.push),
    .wdata_i (front.bundle),
    .full_o  (full),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  pd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .bundle_i   (q_rdata),
    .q_empty_i  (q_empty),
    .q_pop_o    (q_pop),
    .empty_o    (empty),
    .pop_i      (pop),
    .out_byte_o (out_byte_o),
    .out_last_o (out_last_o),
    .overflow_o (overflow_o)
  );

endmodule
